// ----- hdl/swfhp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swfhp_pkg;

    typedef enum logic [4:0] {
        ST_HDR  = 5'b00001,
        ST_WID  = 5'b00010,
        ST_BND  = 5'b00100,
        ST_TAIL = 5'b01000,
        ST_DONE = 5'b10000
    } t_stage;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_SHORT_HDR  = 2'd1;
    localparam logic [1:0] STS_BAD_SIG    = 2'd2;
    localparam logic [1:0] STS_SHORT_BODY = 2'd3;

    // signature bytes, first byte in the low lane
    localparam logic [23:0] SIG_FWS = 24'h535746;
    localparam logic [23:0] SIG_CWS = 24'h535743;

    localparam logic [4:0] WIDTH_FIELD_BITS = 5'd5;

    // x / 20 == (x >> 2) / 5; /5 by reciprocal, exact for 32-bit operands
    localparam logic [31:0] RECIP_FIVE = 32'hCCCCCCCD;
    localparam int          RECIP_SHIFT = 34;

    typedef struct packed {
        logic [1:0]         status;
        logic               compressed;
        logic [7:0]         version;
        logic [31:0]        movie_len;
        logic signed [27:0] pix_width;
        logic signed [27:0] pix_height;
        logic [15:0]        frame_rate;
        logic [15:0]        frame_total;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/swf_header_field_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result is registered from its last byte, or goes to the skid entry while the output stalls.
// Throughput: one byte per cycle unless the skid entry is full; a byte is parsed in one pass.
// Width and height come from a three-stage divide-by-20 pipeline that runs behind the bounds.
// A two-entry output stage keeps input flowing while a result waits for its transfer.
// Reset (synchronous, active low) clears the parse state and drops pending results.

module swf_header_field_parser_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_end_of_stream,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_status,
    output logic                    o_compressed,
    output logic [7:0]              o_version,
    output logic [31:0]             o_movie_len,
    output logic signed [27:0]      o_pix_width,
    output logic signed [27:0]      o_pix_height,
    output logic [15:0]             o_frame_rate,
    output logic [15:0]             o_frame_total
);

    swfhp_pkg::t_stage r_stage, n_stage;
    logic [2:0]        r_cnt, n_cnt;
    logic [4:0]        r_fw, n_fw;
    logic [2:0]        r_idx, n_idx;
    logic [30:0]       r_acc, n_acc;
    logic [4:0]        r_left, n_left;
    logic [30:0]       r_rect [4];
    logic [30:0]       n_rect [4];
    logic [23:0]       r_sig, n_sig;
    logic [7:0]        r_ver, n_ver;
    logic [31:0]       r_len, n_len;
    logic [31:0]       r_tail, n_tail;

    logic               r_out_v, r_skid_v;
    swfhp_pkg::t_result r_out, r_skid, n_res;
    logic               accept, emit;

    logic signed [31:0] r_dx, r_dy;
    logic [30:0]        r_wmag, r_hmag;
    logic               r_wneg_b, r_hneg_b, r_wneg_c, r_hneg_c;
    logic [60:0]        r_wprod, r_hprod;
    logic [27:0]        w_q, h_q, w_px, h_px;

    function automatic logic signed [31:0] sext_bound(input logic [30:0] raw,
                                                      input logic [4:0] n);
        logic [31:0] v;
        v = {1'b0, raw};
        if (n != 5'd0 && raw[n - 5'd1]) begin
            v = v - (32'd1 << n);
        end
        return signed'(v);
    endfunction

    assign o_in_ready = !r_skid_v;
    assign accept     = i_in_valid && o_in_ready;

    // divide-by-20 pipeline, free running behind the bound registers
    always_ff @(posedge i_clk) begin
        r_dx     <= sext_bound(r_rect[1], r_fw) - sext_bound(r_rect[0], r_fw);
        r_dy     <= sext_bound(r_rect[3], r_fw) - sext_bound(r_rect[2], r_fw);
        r_wneg_b <= r_dx[31];
        r_hneg_b <= r_dy[31];
        r_wmag   <= r_dx[31] ? 31'(-r_dx) : r_dx[30:0];
        r_hmag   <= r_dy[31] ? 31'(-r_dy) : r_dy[30:0];
        r_wneg_c <= r_wneg_b;
        r_hneg_c <= r_hneg_b;
        r_wprod  <= r_wmag[30:2] * swfhp_pkg::RECIP_FIVE;
        r_hprod  <= r_hmag[30:2] * swfhp_pkg::RECIP_FIVE;
    end

    assign w_q  = {1'b0, r_wprod[60:swfhp_pkg::RECIP_SHIFT]};
    assign h_q  = {1'b0, r_hprod[60:swfhp_pkg::RECIP_SHIFT]};
    assign w_px = r_wneg_c ? 28'(-w_q) : w_q;
    assign h_px = r_hneg_c ? 28'(-h_q) : h_q;

    always_comb begin
        n_stage = r_stage;
        n_cnt   = r_cnt;
        n_fw    = r_fw;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_left  = r_left;
        n_rect  = r_rect;
        n_sig   = r_sig;
        n_ver   = r_ver;
        n_len   = r_len;
        n_tail  = r_tail;
        emit    = 1'b0;
        n_res   = '0;

        if (accept) begin
            unique case (r_stage) inside
                swfhp_pkg::ST_HDR: begin
                    if (r_cnt < 3'd3) begin
                        n_sig[8*r_cnt[1:0] +: 8] = i_data_byte;
                    end else if (r_cnt == 3'd3) begin
                        n_ver = i_data_byte;
                    end else begin
                        n_len[8*r_cnt[1:0] +: 8] = i_data_byte;
                    end
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        if (r_sig != swfhp_pkg::SIG_FWS && r_sig != swfhp_pkg::SIG_CWS) begin
                            emit            = 1'b1;
                            n_res.status    = swfhp_pkg::STS_BAD_SIG;
                            n_res.version   = r_ver;
                            n_res.movie_len = n_len;
                            n_stage         = swfhp_pkg::ST_DONE;
                        end else begin
                            n_stage = swfhp_pkg::ST_WID;
                            n_cnt   = 3'd0;
                            n_acc   = '0;
                            n_left  = swfhp_pkg::WIDTH_FIELD_BITS;
                        end
                    end
                end
                swfhp_pkg::ST_WID, swfhp_pkg::ST_BND: begin
                    for (int b = 7; b >= 0; b--) begin
                        if (n_stage == swfhp_pkg::ST_WID) begin
                            n_acc  = {n_acc[29:0], i_data_byte[b]};
                            n_left = n_left - 5'd1;
                            if (n_left == 5'd0) begin
                                n_fw   = n_acc[4:0];
                                n_acc  = '0;
                                n_idx  = 3'd0;
                                n_left = n_fw;
                                if (n_fw == 5'd0) begin
                                    n_stage = swfhp_pkg::ST_TAIL;
                                    n_cnt   = 3'd0;
                                end else begin
                                    n_stage = swfhp_pkg::ST_BND;
                                end
                            end
                        end else if (n_stage == swfhp_pkg::ST_BND) begin
                            n_acc  = {n_acc[29:0], i_data_byte[b]};
                            n_left = n_left - 5'd1;
                            if (n_left == 5'd0) begin
                                n_rect[n_idx[1:0]] = n_acc;
                                n_acc  = '0;
                                n_idx  = n_idx + 3'd1;
                                n_left = n_fw;
                                if (n_idx == 3'd4) begin
                                    n_stage = swfhp_pkg::ST_TAIL;
                                    n_cnt   = 3'd0;
                                end
                            end
                        end
                    end
                end
                swfhp_pkg::ST_TAIL: begin
                    n_tail[8*r_cnt[1:0] +: 8] = i_data_byte;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        emit              = 1'b1;
                        n_res.status      = swfhp_pkg::STS_OK;
                        n_res.compressed  = (r_sig == swfhp_pkg::SIG_CWS);
                        n_res.version     = r_ver;
                        n_res.movie_len   = r_len;
                        n_res.pix_width   = w_px;
                        n_res.pix_height  = h_px;
                        n_res.frame_rate  = n_tail[15:0];
                        n_res.frame_total = n_tail[31:16];
                        n_stage           = swfhp_pkg::ST_DONE;
                    end
                end
                default: begin
                end
            endcase

            if (i_end_of_stream) begin
                if (!emit && n_stage != swfhp_pkg::ST_DONE) begin
                    emit = 1'b1;
                    if (n_stage == swfhp_pkg::ST_HDR) begin
                        n_res.status = swfhp_pkg::STS_SHORT_HDR;
                    end else begin
                        n_res.status     = swfhp_pkg::STS_SHORT_BODY;
                        n_res.compressed = (n_sig == swfhp_pkg::SIG_CWS);
                        n_res.version    = n_ver;
                        n_res.movie_len  = n_len;
                    end
                end
                n_stage = swfhp_pkg::ST_HDR;
                n_cnt   = '0;
                n_fw    = '0;
                n_idx   = '0;
                n_acc   = '0;
                n_left  = '0;
                n_rect  = '{default: '0};
                n_sig   = '0;
                n_ver   = '0;
                n_len   = '0;
                n_tail  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= swfhp_pkg::ST_HDR;
            r_cnt   <= '0;
            r_fw    <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
            r_left  <= '0;
            r_rect  <= '{default: '0};
            r_sig   <= '0;
            r_ver   <= '0;
            r_len   <= '0;
            r_tail  <= '0;
        end else begin
            r_stage <= n_stage;
            r_cnt   <= n_cnt;
            r_fw    <= n_fw;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_rect  <= n_rect;
            r_sig   <= n_sig;
            r_ver   <= n_ver;
            r_len   <= n_len;
            r_tail  <= n_tail;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            r_out_v  <= r_skid_v || emit;
            r_skid_v <= 1'b0;
        end else if (emit) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (emit) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_status      = r_out.status;
    assign o_compressed  = r_out.compressed;
    assign o_version     = r_out.version;
    assign o_movie_len   = r_out.movie_len;
    assign o_pix_width   = r_out.pix_width;
    assign o_pix_height  = r_out.pix_height;
    assign o_frame_rate  = r_out.frame_rate;
    assign o_frame_total = r_out.frame_total;

endmodule

`default_nettype wire
